FILE: src/isort_pkg.sv
`timescale 1ns / 1ps
package isort_pkg;

	localparam int VALUE_W       = 20;
	localparam int DEPTH_DEFAULT = 64;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} isort_state_t;

	// per-cycle command broadcast along the chain
	typedef struct packed {
		logic ins;
		logic shift;
	} isort_ctrl_t;

endpackage

FILE: src/isort_cell.sv
`timescale 1ns / 1ps
module isort_cell (
	input  logic                                clk,
	input  isort_pkg::isort_ctrl_t              ctrl,
	input  logic                                occ,
	input  logic [isort_pkg::VALUE_W-1:0]       din,
	input  logic [isort_pkg::VALUE_W-1:0]       left_val,
	input  logic                                left_gt,
	input  logic [isort_pkg::VALUE_W-1:0]       right_val,
	output logic [isort_pkg::VALUE_W-1:0]       val,
	output logic                                gt
);

	logic [isort_pkg::VALUE_W-1:0] val_q;

	// an empty cell counts as greater than anything
	assign gt  = !occ || (val_q > din);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && gt) begin
			val_q <= left_gt ? left_val : din;
		end else if (ctrl.shift) begin
			val_q <= right_val;
		end
	end

endmodule

FILE: src/insertion_sorter_unit.sv
`timescale 1ns / 1ps
// channel | direction | words           | handshake
// in      | input     | value, last     | in_valid / in_ready
// out     | output    | value_res, last_out, overflow | out_valid / out_ready
//
// one input word per cycle while filling; every cell compares the word at once
// and the greater stored values move one cell along the chain.
// a word with last set starts a drain of the n words held (n = 1..DEPTH), one
// result per cycle out of cell 0 while out_ready is high; input is held off
// during the drain. reset clears the fill count, the drop flag and the state;
// no clearing pass. output stalls simply hold the chain in place.
module insertion_sorter_unit #(
	parameter int DEPTH = isort_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [isort_pkg::VALUE_W-1:0] value,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [isort_pkg::VALUE_W-1:0] value_res,
	output logic                          last_out,
	output logic                          overflow
);

	localparam int CW = $clog2(DEPTH + 1);

	isort_pkg::isort_state_t state_q, state_d;
	logic [CW-1:0]           count_q;
	logic                    drop_q;
	isort_pkg::isort_ctrl_t  ctrl;

	logic [isort_pkg::VALUE_W-1:0] cell_val [DEPTH];
	logic [DEPTH-1:0]              cell_gt;
	logic [DEPTH-1:0]              cell_occ;

	logic accept, full, pop, final_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign in_ready  = (state_q == isort_pkg::ST_FILL);
	assign out_valid = (state_q == isort_pkg::ST_DRAIN);
	assign accept    = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign final_pop = pop && (count_q == CW'(1));

	assign ctrl.ins   = accept && !full;
	assign ctrl.shift = pop;

	assign value_res = cell_val[0];
	assign last_out  = (count_q == CW'(1));
	assign overflow  = drop_q;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic [isort_pkg::VALUE_W-1:0] lv, rv;
			logic                          lg;

			assign cell_occ[i] = (CW'(i) < count_q);

			if (i == 0) begin : g_first
				assign lv = value;
				assign lg = 1'b0;
			end else begin : g_mid
				assign lv = cell_val[i-1];
				assign lg = cell_gt[i-1];
			end

			if (i == DEPTH - 1) begin : g_end
				assign rv = cell_val[i];
			end else begin : g_inner
				assign rv = cell_val[i+1];
			end

			isort_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occ       (cell_occ[i]),
				.din       (value),
				.left_val  (lv),
				.left_gt   (lg),
				.right_val (rv),
				.val       (cell_val[i]),
				.gt        (cell_gt[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isort_pkg::ST_FILL;
			count_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.ins) begin
				count_q <= count_q + CW'(1);
			end else if (pop) begin
				count_q <= count_q - CW'(1);
			end
			if (accept && full) begin
				drop_q <= 1'b1;
			end else if (final_pop) begin
				drop_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			isort_pkg::ST_FILL: begin
				if (accept && last) begin
					state_d = isort_pkg::ST_DRAIN;
				end
			end
			isort_pkg::ST_DRAIN: begin
				if (final_pop) begin
					state_d = isort_pkg::ST_FILL;
				end
			end
			default: state_d = isort_pkg::ST_FILL;
		endcase
	end

endmodule

FILE: src/isort_checker.sv
`timescale 1ns / 1ps
module isort_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          last,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [isort_pkg::VALUE_W-1:0] value_res,
	input logic                          last_out,
	input logic                          overflow
);

	// no input taken while a batch drains
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted during drain");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> out_valid)
		else $error("last word did not start drain");

	// results come out in ascending order, with overflow steady until the last
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_out |=>
			out_valid && (value_res >= $past(value_res)) && (overflow == $past(overflow)))
		else $error("results out of order");

	a_end_of_batch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_out |=> !out_valid && in_ready)
		else $error("drain did not end after final word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value_res) && $stable(last_out))
		else $error("stalled result changed");

endmodule

bind insertion_sorter_unit isort_checker u_isort_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.last      (last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.value_res (value_res),
	.last_out  (last_out),
	.overflow  (overflow)
);
